/* hdl/conv3x3_replicate_border_assert.svh */
// Assertion macros shared by the 3x3 convolution block.
`ifndef CONV3X3_REPLICATE_BORDER_ASSERT_SVH
`define CONV3X3_REPLICATE_BORDER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/c3rb_pkg.sv */
// Types and constants of the 3x3 replicate-border convolution block.
package c3rb_pkg;

	localparam int PIX_W       = 8;
	localparam int FILT_W      = 28;
	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_W    = 13;
	localparam int KROW_W      = 48;
	localparam int CFG_DATA_W  = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int KSIZE       = 3;

	localparam logic KIND_DRAIN = 1'b1;

	localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = WIDTH_REG_W'(1024);
	localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = HEIGHT_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_KERNEL_TOP    = 3'd2,
		REG_KERNEL_MID    = 3'd3,
		REG_KERNEL_BOTTOM = 3'd4
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic kind;
		pix_t pixel;
	} pix_item_t;

	typedef struct packed {
		logic signed [FILT_W-1:0] filtered;
		logic                     last_of_run;
		logic                     end_of_frame;
	} res_item_t;

	// One new window column, index 0 is the top row, plus what results it causes.
	typedef struct packed {
		logic [KSIZE-1:0][PIX_W-1:0] column;
		logic                        emit_a;
		logic                        emit_b;
		logic                        a_left_is1;
		logic                        b_left_is2;
		logic                        drain;
	} win_upd_t;

	// Nine taps of one result, [kernel row][kernel column].
	typedef struct packed {
		logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] taps;
		logic                                   last_of_run;
		logic                                   end_of_frame;
	} job_t;

	typedef logic [KSIZE-1:0][KROW_W-1:0] kernel_t;

endpackage

/* hdl/c3rb_stream_if.sv */
// Valid/ready stream interfaces for pixel and result transactions.
interface c3rb_pix_if
	import c3rb_pkg::*;
();
	logic      valid;
	logic      ready;
	pix_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface c3rb_res_if
	import c3rb_pkg::*;
();
	logic      valid;
	logic      ready;
	res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/c3rb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module c3rb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents on a same-address write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/c3rb_window.sv */
// 3x3 window register, result sequencer and tap register.
module c3rb_window
	import c3rb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     upd_valid,
	input  win_upd_t upd,
	output logic     upd_ready,
	output logic     job_valid,
	output job_t     job,
	input  logic     job_ready
);

	pix_t window_q [KSIZE][KSIZE];
	logic pend_a_q;
	logic pend_b_q;
	logic a_left_is1_q;
	logic b_left_is2_q;
	logic drain_q;

	logic job_valid_s3;
	job_t job_s3;

	logic busy;
	logic s3_free;
	logic emit;
	logic final_job;
	logic load;
	job_t job_d;

	assign busy      = pend_a_q | pend_b_q;
	assign s3_free   = !job_valid_s3 || job_ready;
	assign emit      = busy && s3_free;
	assign final_job = pend_a_q ? !pend_b_q : 1'b1;
	assign upd_ready = !busy || (emit && final_job);
	assign load      = upd_valid && upd_ready;

	// Pick the window columns for the pending result; right column is always 2.
	always_comb begin
		job_d = '0;
		for (int r = 0; r < KSIZE; r++) begin
			if (pend_a_q) begin
				job_d.taps[r][0] = a_left_is1_q ? window_q[r][1] : window_q[r][0];
				job_d.taps[r][1] = window_q[r][1];
			end else begin
				job_d.taps[r][0] = b_left_is2_q ? window_q[r][2] : window_q[r][1];
				job_d.taps[r][1] = window_q[r][2];
			end
			job_d.taps[r][2] = window_q[r][2];
		end
		job_d.last_of_run  = final_job;
		job_d.end_of_frame = !pend_a_q && drain_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < KSIZE; r++) begin
				for (int c = 0; c < KSIZE; c++) begin
					window_q[r][c] <= '0;
				end
			end
			pend_a_q     <= 1'b0;
			pend_b_q     <= 1'b0;
			job_valid_s3 <= 1'b0;
		end else begin
			if (load) begin
				for (int r = 0; r < KSIZE; r++) begin
					window_q[r][0] <= window_q[r][1];
					window_q[r][1] <= window_q[r][2];
					window_q[r][2] <= upd.column[r];
				end
				pend_a_q <= upd.emit_a;
				pend_b_q <= upd.emit_b;
			end else if (emit) begin
				if (pend_a_q) begin
					pend_a_q <= 1'b0;
				end else begin
					pend_b_q <= 1'b0;
				end
			end
			if (emit) begin
				job_valid_s3 <= 1'b1;
			end else if (job_ready) begin
				job_valid_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_left_is1_q <= upd.a_left_is1;
			b_left_is2_q <= upd.b_left_is2;
			drain_q      <= upd.drain;
		end
		if (emit) begin
			job_s3 <= job_d;
		end
	end

	assign job_valid = job_valid_s3;
	assign job       = job_s3;

endmodule

/* hdl/c3rb_mac.sv */
// Nine-tap multiply stage and summing result register.
module c3rb_mac
	import c3rb_pkg::*;
#(
	parameter int COEF_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	input  job_t    job,
	output logic    job_ready,
	input  kernel_t kern,
	c3rb_res_if.source results
);

	localparam int PROD_W = COEF_BITS + PIX_W + 1;
	localparam int SUM_W  = (PROD_W + 4 > FILT_W) ? PROD_W + 4 : FILT_W;

	logic signed [COEF_BITS-1:0] coef [KSIZE][KSIZE];
	logic signed [PROD_W-1:0]    prod_d [KSIZE][KSIZE];
	logic signed [PROD_W-1:0]    prod_s4 [KSIZE][KSIZE];
	logic                        valid_s4;
	logic                        last_s4;
	logic                        eof_s4;
	logic signed [SUM_W-1:0]     acc;
	logic                        res_valid_q;
	res_item_t                   res_q;
	logic                        out_free;
	logic                        s4_free;

	// Coefficient bits past the 48-bit row read as zero.
	for (genvar r = 0; r < KSIZE; r++) begin : g_row
		for (genvar c = 0; c < KSIZE; c++) begin : g_col
			for (genvar b = 0; b < COEF_BITS; b++) begin : g_bit
				if (c * COEF_BITS + b < KROW_W) begin : g_in
					assign coef[r][c][b] = kern[r][c * COEF_BITS + b];
				end else begin : g_out
					assign coef[r][c][b] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		for (int r = 0; r < KSIZE; r++) begin
			for (int c = 0; c < KSIZE; c++) begin
				prod_d[r][c] = $signed({1'b0, job.taps[r][c]}) * coef[r][c];
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int r = 0; r < KSIZE; r++) begin
			for (int c = 0; c < KSIZE; c++) begin
				acc = acc + SUM_W'(prod_s4[r][c]);
			end
		end
	end

	assign out_free  = !res_valid_q || results.ready;
	assign s4_free   = !valid_s4 || out_free;
	assign job_ready = s4_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s4_free) begin
				valid_s4 <= job_valid;
			end
			if (out_free) begin
				res_valid_q <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && s4_free) begin
			prod_s4 <= prod_d;
			last_s4 <= job.last_of_run;
			eof_s4  <= job.end_of_frame;
		end
		if (valid_s4 && out_free) begin
			res_q.filtered     <= acc[FILT_W-1:0];
			res_q.last_of_run  <= last_s4;
			res_q.end_of_frame <= eof_s4;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

endmodule

/* hdl/conv3x3_replicate_border.sv */
// Top level of the streaming 3x3 convolution with replicated image border.
//
// Streaming 3x3 correlation (kernel not flipped) of 8-bit gray pixels with
// signed Q2.13 coefficients, replicate border. Send the frame in raster order,
// then one row of image_width drain transactions that stand for the replicated
// bottom row. The result for pixel (r-1,c-1) leaves when pixel (r,c) has gone
// in; the last column of each row gives a second result from the same input,
// and row zero gives none. filtered is the full-precision sum, read as
// value/(255*8192), wrapped to 28 bits only when COEF_BITS exceeds 16.
// Throughput: one input transaction per clock while results are taken. An
// input on the last column of a row causes two results; the single output
// port takes them in turn, so the input is held at each row end. Registered
// steps from accept to result register: line-store read, window/sequencer,
// multiply, sum. The two line stores share one MAX_WIDTH x 16 RAM, read and
// written once per pixel; a same-address read and write in one clock (width
// of one) is resolved by a bypass register. The line stores need no clearing
// after reset. Write the configuration registers only while the block is idle.
`include "conv3x3_replicate_border_assert.svh"

module conv3x3_replicate_border
	import c3rb_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int COEF_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	c3rb_pix_if.sink              pixels,
	c3rb_res_if.source            results
);

	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMP_W  = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
		$clog2(MAX_WIDTH + 1) : WIDTH_REG_W;
	localparam int LINE_W = 2 * PIX_W;

	// Configuration registers.
	logic [WIDTH_REG_W-1:0] width_q;
	logic [HEIGHT_W-1:0]    height_q;
	kernel_t                kern_q;

	// Raster position of the next transaction.
	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] row_q;

	logic [CMP_W-1:0]    w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic                last;
	logic                drain;
	logic                in_acc;

	// Stage 1: line-store read in flight.
	logic             valid_s1;
	logic [COL_W-1:0] idx_s1;
	logic             kind_s1;
	pix_t             pixel_s1;
	logic             drain_s1;
	logic             last_s1;
	logic             row_is1_s1;
	logic             row_ge1_s1;
	logic             col_is0_s1;
	logic             col_is1_s1;
	logic             byp_sel_s1;
	logic [LINE_W-1:0] byp_s1;

	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] line;
	logic [LINE_W-1:0] line_wdata;
	pix_t              top;
	pix_t              mid;
	pix_t              bot;
	logic              s1_retire;

	win_upd_t upd;
	logic     upd_ready;
	logic     job_valid;
	job_t     job;
	logic     job_ready;

	// Configuration writes; indexes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			kern_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:   width_q   <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT:  height_q  <= cfg_data[HEIGHT_W-1:0];
				REG_KERNEL_TOP:    kern_q[0] <= cfg_data[KROW_W-1:0];
				REG_KERNEL_MID:    kern_q[1] <= cfg_data[KROW_W-1:0];
				REG_KERNEL_BOTTOM: kern_q[2] <= cfg_data[KROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp width to 1..MAX_WIDTH and height to at least 1.
	always_comb begin
		if (width_q == '0) begin
			w_eff = CMP_W'(1);
		end else if (CMP_W'(width_q) > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end else begin
			w_eff = CMP_W'(width_q);
		end
		h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	end

	// A column at or past the end counts as the last one (width may shrink).
	assign last  = (CMP_W'(col_q) + CMP_W'(1)) >= w_eff;
	// Any row at or past the height is the drain row.
	assign drain = row_q >= h_eff;

	assign s1_retire    = valid_s1 && upd_ready;
	assign pixels.ready = !valid_s1 || s1_retire;
	assign in_acc       = pixels.valid && pixels.ready;

	// Advance the raster position as each transaction is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				if (last) begin
					col_q <= '0;
					row_q <= drain ? '0 : row_q + HEIGHT_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
				valid_s1 <= 1'b1;
			end else if (s1_retire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Capture the transaction and its position flags; the RAM read runs alongside.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_s1     <= col_q;
			kind_s1    <= pixels.data.kind;
			pixel_s1   <= pixels.data.pixel;
			drain_s1   <= drain;
			last_s1    <= last;
			row_is1_s1 <= row_q == HEIGHT_W'(1);
			row_ge1_s1 <= row_q != '0;
			col_is0_s1 <= col_q == '0;
			col_is1_s1 <= col_q == COL_W'(1);
			// The RAM returns stale data when the retiring pixel writes this address.
			byp_sel_s1 <= s1_retire && (col_q == idx_s1);
			byp_s1     <= line_wdata;
		end
	end

	c3rb_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_retire),
		.waddr(idx_s1),
		.wdata(line_wdata),
		.re   (in_acc),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// Upper line store in the high byte, lower in the low byte.
	always_comb begin
		line = byp_sel_s1 ? byp_s1 : ram_rdata;
		mid  = line[PIX_W-1:0];
		// On row one the row above is row zero itself (top edge replicated).
		top  = row_is1_s1 ? mid : line[LINE_W-1:PIX_W];
		// Drain items and drain rows stand for the pixel above.
		bot  = (drain_s1 || (kind_s1 == KIND_DRAIN)) ? mid : pixel_s1;
		line_wdata = {mid, bot};
	end

	always_comb begin
		upd.column[0]  = top;
		upd.column[1]  = mid;
		upd.column[2]  = bot;
		upd.emit_a     = row_ge1_s1 && !col_is0_s1;
		upd.emit_b     = row_ge1_s1 && last_s1;
		// Left edge: column 0 stands in for column -1.
		upd.a_left_is1 = col_is1_s1;
		// Width of one: the single column fills all three taps.
		upd.b_left_is2 = col_is0_s1;
		upd.drain      = drain_s1;
	end

	c3rb_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd_valid(valid_s1),
		.upd      (upd),
		.upd_ready(upd_ready),
		.job_valid(job_valid),
		.job      (job),
		.job_ready(job_ready)
	);

	c3rb_mac #(
		.COEF_BITS(COEF_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (job),
		.job_ready(job_ready),
		.kern     (kern_q),
		.results  (results)
	);

	// The bottom right result always closes the run of its input.
	`ASSERT_IMPLIES(a_eof_is_last, clk, arst_n, results.valid && results.data.end_of_frame, results.data.last_of_run)
	// An accepted transaction always occupies stage 1 on the next clock.
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_acc, valid_s1)
	// A read colliding with the retiring write must take the bypass path.
	`ASSERT_NEXT(a_collision_bypass, clk, arst_n, in_acc && s1_retire && (col_q == idx_s1), byp_sel_s1)

endmodule
